[src/c8_pkg.sv]
// shared constants, types and a helper function for the chip-8 core
package c8_pkg;

  localparam int MEMORY_BYTES  = 4096;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int STACK_DEPTH   = 16;
  localparam int NUM_REGS      = 16;

  localparam logic [11:0] PROGRAM_BASE = 12'h200;
  localparam logic [11:0] FONT_BASE    = 12'h050;
  localparam int          FONT_BYTES   = 80;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_EXEC  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // opcode groups, top nibble
  localparam logic [3:0] OPC_SYS    = 4'h0;
  localparam logic [3:0] OPC_JP     = 4'h1;
  localparam logic [3:0] OPC_CALL   = 4'h2;
  localparam logic [3:0] OPC_SE_I   = 4'h3;
  localparam logic [3:0] OPC_SNE_I  = 4'h4;
  localparam logic [3:0] OPC_SE_R   = 4'h5;
  localparam logic [3:0] OPC_LD_I   = 4'h6;
  localparam logic [3:0] OPC_ADD_I  = 4'h7;
  localparam logic [3:0] OPC_ALU    = 4'h8;
  localparam logic [3:0] OPC_SNE_R  = 4'h9;
  localparam logic [3:0] OPC_LD_IDX = 4'hA;
  localparam logic [3:0] OPC_JP_V0  = 4'hB;
  localparam logic [3:0] OPC_RND    = 4'hC;
  localparam logic [3:0] OPC_DRW    = 4'hD;
  localparam logic [3:0] OPC_KEY    = 4'hE;
  localparam logic [3:0] OPC_MISC   = 4'hF;

  localparam logic [15:0] W_CLS = 16'h00E0;
  localparam logic [15:0] W_RET = 16'h00EE;

  // register-register operations, low nibble
  localparam logic [3:0] N_MOV  = 4'h0;
  localparam logic [3:0] N_OR   = 4'h1;
  localparam logic [3:0] N_AND  = 4'h2;
  localparam logic [3:0] N_XOR  = 4'h3;
  localparam logic [3:0] N_ADD  = 4'h4;
  localparam logic [3:0] N_SUB  = 4'h5;
  localparam logic [3:0] N_SHR  = 4'h6;
  localparam logic [3:0] N_SUBN = 4'h7;
  localparam logic [3:0] N_SHL  = 4'hE;

  localparam logic [7:0] K_SKP  = 8'h9E;
  localparam logic [7:0] K_SKNP = 8'hA1;

  localparam logic [7:0] F_GDT  = 8'h07;
  localparam logic [7:0] F_WK   = 8'h0A;
  localparam logic [7:0] F_SDT  = 8'h15;
  localparam logic [7:0] F_SST  = 8'h18;
  localparam logic [7:0] F_ADDI = 8'h1E;
  localparam logic [7:0] F_FONT = 8'h29;
  localparam logic [7:0] F_BCD  = 8'h33;
  localparam logic [7:0] F_STR  = 8'h55;
  localparam logic [7:0] F_LDR  = 8'h65;

  localparam logic [3:0] FLAG_REG = 4'hF;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [3:0] {
    ALU_PASS, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
    ALU_SUB, ALU_SUBN, ALU_SHR, ALU_SHL
  } alu_fn_t;

  typedef struct packed {
    alu_fn_t    fn;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] res;
    logic [7:0] flag;
  } alu_rsp_t;

  typedef struct packed {
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] units;
  } bcd_t;

  // tens digit by reciprocal multiply, valid for remainders below 100
  function automatic bcd_t to_bcd(input logic [7:0] v);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [15:0] p;
    logic [3:0]  t;
    bcd_t        d;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - 8'(h) * 8'd100;
    p = 16'(r) * 16'd205;
    t = p[14:11];
    d.hundreds = {2'b00, h};
    d.tens     = t;
    d.units    = 4'(r - 8'(t) * 8'd10);
    return d;
  endfunction

endpackage

[src/c8_ram.sv]
// generic single-write, single-read ram with registered read data
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

endmodule

[src/c8_alu.sv]
// shared 8-bit arithmetic and logic unit with flag output
module c8_alu (
  input  c8_pkg::alu_req_t req,
  output c8_pkg::alu_rsp_t rsp
);

  logic [8:0] sum;

  assign sum = {1'b0, req.a} + {1'b0, req.b};

  always_comb begin
    rsp = '0;
    unique case (req.fn)
      c8_pkg::ALU_PASS: rsp.res = req.b;
      c8_pkg::ALU_OR:   rsp.res = req.a | req.b;
      c8_pkg::ALU_AND:  rsp.res = req.a & req.b;
      c8_pkg::ALU_XOR:  rsp.res = req.a ^ req.b;
      c8_pkg::ALU_ADD: begin
        rsp.res  = sum[7:0];
        rsp.flag = {7'd0, sum[8]};
      end
      c8_pkg::ALU_SUB: begin
        rsp.res  = req.a - req.b;
        rsp.flag = {7'd0, req.a > req.b};
      end
      c8_pkg::ALU_SUBN: begin
        rsp.res  = req.b - req.a;
        rsp.flag = {7'd0, req.b > req.a};
      end
      c8_pkg::ALU_SHR: begin
        rsp.res  = {1'b0, req.a[7:1]};
        rsp.flag = {7'd0, req.a[0]};
      end
      c8_pkg::ALU_SHL: begin
        rsp.res  = {req.a[6:0], 1'b0};
        rsp.flag = {7'd0, req.a[7]};
      end
      default: rsp = '0;
    endcase
  end

endmodule

[src/eight_bit_vm_cpu_core_unit.sv]
// chip-8 interpreter core: sequencer, state registers and memories
// After reset a clearing pass (font load, memory, register file and frame buffer
// clear) runs with busy high. A write passes S_FIN, a row read S_RROW and S_FIN,
// an instruction S_F0 to S_F5, S_EXEC and S_FIN plus its work: S_D0/S_D1 per
// sprite row and S_DFLAG for Dxyn, S_CLS per row for 00E0, S_BCD per digit for
// Fx33, S_ST0/S_ST1 or S_LD0/S_LD1 per register for Fx55 and Fx65, S_WRX for a
// flag-writing 8xyN, S_RET for 00EE, bounded by one write and one read port per
// memory. The result appears for one cycle with done high and cannot be held off.
module eight_bit_vm_cpu_core_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [11:0] address,
  input  logic [7:0]  data,
  input  logic [15:0] keys,
  input  logic [7:0]  random_byte,
  input  logic [4:0]  row,
  output logic        done,
  output logic [11:0] program_counter,
  output logic [15:0] opcode_executed,
  output logic [15:0] index_value,
  output logic [7:0]  flag_value,
  output logic [7:0]  delay_timer_value,
  output logic [7:0]  sound_timer_value,
  output logic        key_wait,
  output logic [63:0] row_pixels
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_EXEC, S_WRX, S_RET,
    S_CLS, S_D0, S_D1, S_DFLAG, S_BCD, S_ST0, S_ST1, S_LD0, S_LD1, S_RROW, S_FIN
  } state_t;

  state_t      state;
  logic [11:0] pc;
  logic [15:0] idx;
  logic [3:0]  sp;
  logic [7:0]  dly, snd, vf, vx, vy, v0, res, rnd_q;
  logic [15:0] op, keys_q;
  logic [1:0]  cmd;
  logic [11:0] cnt;
  logic        coll, wait_q;
  logic [63:0] pix;

  logic        mem_we, rf_we, stk_we, fb_we;
  logic [11:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata, mem_rdata, rf_wdata, rf_rdata;
  logic [3:0]  rf_waddr, rf_raddr, stk_waddr, stk_raddr;
  logic [11:0] stk_wdata, stk_rdata;
  logic [4:0]  fb_waddr, fb_raddr;
  logic [63:0] fb_wdata, fb_rdata;

  c8_pkg::alu_req_t alu_req;
  c8_pkg::alu_rsp_t alu_rsp;

  logic [3:0]  nib, x, n;
  logic [7:0]  kk;
  logic [11:0] nnn, pc2, pc_exec;
  logic        skip, key_dn, key_hit, flag_op;
  logic [3:0]  key_idx;
  logic [5:0]  drow;
  logic [63:0] smask;
  c8_pkg::bcd_t digits;

  c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::MEMORY_BYTES)) u_mem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata));

  c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::NUM_REGS)) u_rf (
    .clk, .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata));

  c8_ram #(.WIDTH(12), .DEPTH(c8_pkg::STACK_DEPTH)) u_stk (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));

  c8_ram #(.WIDTH(c8_pkg::SCREEN_WIDTH), .DEPTH(c8_pkg::SCREEN_HEIGHT)) u_fb (
    .clk, .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
    .raddr(fb_raddr), .rdata(fb_rdata));

  c8_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  assign busy   = (state != S_IDLE);
  assign nib    = op[15:12];
  assign x      = op[11:8];
  assign n      = op[3:0];
  assign kk     = op[7:0];
  assign nnn    = op[11:0];
  assign pc2    = pc + 12'd2;
  assign key_dn = (vx < 8'd16) && keys_q[vx[3:0]];
  assign drow   = {1'b0, vy[4:0]} + cnt[5:0];
  assign smask  = {mem_rdata, 56'd0} >> vx[5:0];
  assign digits = c8_pkg::to_bcd(vx);

  // lowest pressed key
  always_comb begin
    key_hit = 1'b0;
    key_idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (keys_q[i]) begin
        key_hit = 1'b1;
        key_idx = 4'(i);
      end
    end
  end

  always_comb begin
    alu_req.a  = vx;
    alu_req.b  = vy;
    alu_req.fn = c8_pkg::ALU_PASS;
    flag_op    = 1'b0;
    case (nib)
      c8_pkg::OPC_ADD_I: begin
        alu_req.fn = c8_pkg::ALU_ADD;
        alu_req.b  = kk;
      end
      c8_pkg::OPC_RND: begin
        alu_req.fn = c8_pkg::ALU_AND;
        alu_req.a  = rnd_q;
        alu_req.b  = kk;
      end
      c8_pkg::OPC_ALU: begin
        case (n)
          c8_pkg::N_OR:   alu_req.fn = c8_pkg::ALU_OR;
          c8_pkg::N_AND:  alu_req.fn = c8_pkg::ALU_AND;
          c8_pkg::N_XOR:  alu_req.fn = c8_pkg::ALU_XOR;
          c8_pkg::N_ADD:  alu_req.fn = c8_pkg::ALU_ADD;
          c8_pkg::N_SUB:  alu_req.fn = c8_pkg::ALU_SUB;
          c8_pkg::N_SUBN: alu_req.fn = c8_pkg::ALU_SUBN;
          c8_pkg::N_SHR:  alu_req.fn = c8_pkg::ALU_SHR;
          c8_pkg::N_SHL:  alu_req.fn = c8_pkg::ALU_SHL;
          default:        alu_req.fn = c8_pkg::ALU_PASS;
        endcase
        flag_op = (n == c8_pkg::N_ADD) || (n == c8_pkg::N_SUB) ||
                  (n == c8_pkg::N_SHR) || (n == c8_pkg::N_SUBN) ||
                  (n == c8_pkg::N_SHL);
      end
      default: alu_req.fn = c8_pkg::ALU_PASS;
    endcase
  end

  // next program counter taken in S_EXEC (00EE reloads it from the stack in S_RET)
  always_comb begin
    skip = 1'b0;
    case (nib)
      c8_pkg::OPC_SE_I:  skip = (vx == kk);
      c8_pkg::OPC_SNE_I: skip = (vx != kk);
      c8_pkg::OPC_SE_R:  skip = (n == 4'd0) && (vx == vy);
      c8_pkg::OPC_SNE_R: skip = (n == 4'd0) && (vx != vy);
      c8_pkg::OPC_KEY:   skip = ((kk == c8_pkg::K_SKP) && key_dn) ||
                                ((kk == c8_pkg::K_SKNP) && !key_dn);
      default:           skip = 1'b0;
    endcase
    pc_exec = skip ? pc2 + 12'd2 : pc2;
    case (nib)
      c8_pkg::OPC_JP, c8_pkg::OPC_CALL: pc_exec = nnn;
      c8_pkg::OPC_JP_V0:                pc_exec = {4'd0, v0} + nnn;
      c8_pkg::OPC_MISC: begin
        if (kk == c8_pkg::F_WK && !key_hit) begin
          pc_exec = pc;
        end
      end
      default: ;
    endcase
  end

  // memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = address;
    mem_wdata = data;
    mem_raddr = pc;
    rf_we     = 1'b0;
    rf_waddr  = x;
    rf_wdata  = alu_rsp.res;
    rf_raddr  = x;
    stk_we    = 1'b0;
    stk_waddr = sp;
    stk_wdata = pc2;
    stk_raddr = sp - 4'd1;
    fb_we     = 1'b0;
    fb_waddr  = drow[4:0];
    fb_wdata  = fb_rdata ^ smask;
    fb_raddr  = drow[4:0];
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = '0;
        if (cnt >= c8_pkg::FONT_BASE &&
            cnt < c8_pkg::FONT_BASE + 12'(c8_pkg::FONT_BYTES)) begin
          mem_wdata = c8_pkg::FONT[7'(cnt - c8_pkg::FONT_BASE)];
        end
        rf_we    = (cnt < 12'(c8_pkg::NUM_REGS));
        rf_waddr = cnt[3:0];
        rf_wdata = '0;
        fb_we    = (cnt < 12'(c8_pkg::SCREEN_HEIGHT));
        fb_waddr = cnt[4:0];
        fb_wdata = '0;
      end
      S_IDLE: begin
        mem_we   = start && (command == c8_pkg::CMD_WRITE);
        fb_raddr = row;
      end
      S_F0: mem_raddr = pc;
      S_F1: mem_raddr = pc + 12'd1;
      S_F2: rf_raddr = x;
      S_F3: rf_raddr = op[7:4];
      S_F4: rf_raddr = '0;
      S_EXEC: begin
        case (nib)
          c8_pkg::OPC_LD_I: begin
            rf_we    = 1'b1;
            rf_wdata = kk;
          end
          c8_pkg::OPC_ADD_I, c8_pkg::OPC_RND: rf_we = 1'b1;
          c8_pkg::OPC_ALU: begin
            if (flag_op) begin
              rf_we    = 1'b1;
              rf_waddr = c8_pkg::FLAG_REG;
              rf_wdata = alu_rsp.flag;
            end else begin
              rf_we = (n == c8_pkg::N_MOV) || (n == c8_pkg::N_OR) ||
                      (n == c8_pkg::N_AND) || (n == c8_pkg::N_XOR);
            end
          end
          c8_pkg::OPC_CALL: stk_we = 1'b1;
          c8_pkg::OPC_MISC: begin
            if (kk == c8_pkg::F_GDT) begin
              rf_we    = 1'b1;
              rf_wdata = dly;
            end else if (kk == c8_pkg::F_WK) begin
              rf_we    = key_hit;
              rf_wdata = {4'd0, key_idx};
            end
          end
          default: ;
        endcase
      end
      S_WRX: begin
        rf_we    = 1'b1;
        rf_wdata = res;
      end
      S_CLS: begin
        fb_we    = 1'b1;
        fb_waddr = cnt[4:0];
        fb_wdata = '0;
      end
      S_D0: mem_raddr = idx[11:0] + cnt;
      S_D1: fb_we = 1'b1;
      S_DFLAG: begin
        rf_we    = 1'b1;
        rf_waddr = c8_pkg::FLAG_REG;
        rf_wdata = {7'd0, coll};
      end
      S_BCD: begin
        mem_we    = 1'b1;
        mem_waddr = idx[11:0] + 12'd2 - cnt;
        case (cnt[1:0])
          2'd0:    mem_wdata = {4'd0, digits.units};
          2'd1:    mem_wdata = {4'd0, digits.tens};
          default: mem_wdata = {4'd0, digits.hundreds};
        endcase
      end
      S_ST0: rf_raddr = cnt[3:0];
      S_ST1: begin
        mem_we    = 1'b1;
        mem_waddr = idx[11:0] + cnt;
        mem_wdata = rf_rdata;
      end
      S_LD0: mem_raddr = idx[11:0] + cnt;
      S_LD1: begin
        rf_we    = 1'b1;
        rf_waddr = cnt[3:0];
        rf_wdata = mem_rdata;
      end
      S_F5, S_RET, S_RROW, S_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      cnt    <= '0;
      pc     <= c8_pkg::PROGRAM_BASE;
      idx    <= '0;
      sp     <= '0;
      dly    <= '0;
      snd    <= '0;
      vf     <= '0;
      done   <= 1'b0;
      wait_q <= 1'b0;
    end else begin
      done <= 1'b0;
      if (rf_we && rf_waddr == c8_pkg::FLAG_REG) begin
        vf <= rf_wdata;
      end
      unique case (state)
        S_INIT: begin
          cnt <= cnt + 12'd1;
          if (cnt == 12'(c8_pkg::MEMORY_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd    <= command;
            keys_q <= keys;
            rnd_q  <= random_byte;
            op     <= '0;
            pix    <= '0;
            wait_q <= 1'b0;
            cnt    <= '0;
            if (command == c8_pkg::CMD_EXEC) begin
              state <= S_F0;
            end else if (command == c8_pkg::CMD_READ) begin
              state <= S_RROW;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_RROW: begin
          pix   <= fb_rdata;
          state <= S_FIN;
        end
        S_F0: state <= S_F1;
        S_F1: begin
          op[15:8] <= mem_rdata;
          state    <= S_F2;
        end
        S_F2: begin
          op[7:0] <= mem_rdata;
          state   <= S_F3;
        end
        S_F3: begin
          vx    <= rf_rdata;
          state <= S_F4;
        end
        S_F4: begin
          vy    <= rf_rdata;
          state <= S_F5;
        end
        S_F5: begin
          v0    <= rf_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          pc    <= pc_exec;
          res   <= alu_rsp.res;
          state <= S_FIN;
          case (nib)
            c8_pkg::OPC_SYS: begin
              if (op == c8_pkg::W_CLS) begin
                state <= S_CLS;
              end else if (op == c8_pkg::W_RET) begin
                sp    <= sp - 4'd1;
                state <= S_RET;
              end
            end
            c8_pkg::OPC_CALL:   sp <= sp + 4'd1;
            c8_pkg::OPC_ALU:    if (flag_op) state <= S_WRX;
            c8_pkg::OPC_LD_IDX: idx <= {4'd0, nnn};
            c8_pkg::OPC_DRW: begin
              coll  <= 1'b0;
              state <= S_D0;
            end
            c8_pkg::OPC_MISC: begin
              case (kk)
                c8_pkg::F_WK:   wait_q <= !key_hit;
                c8_pkg::F_SDT:  dly <= vx;
                c8_pkg::F_SST:  snd <= vx;
                c8_pkg::F_ADDI: idx <= idx + {8'd0, vx};
                c8_pkg::F_FONT: idx <= {4'd0, c8_pkg::FONT_BASE} +
                                       {6'd0, vx, 2'b00} + {8'd0, vx};
                c8_pkg::F_BCD:  state <= S_BCD;
                c8_pkg::F_STR:  state <= S_ST0;
                c8_pkg::F_LDR:  state <= S_LD0;
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        S_WRX: state <= S_FIN;
        S_RET: begin
          pc    <= stk_rdata;
          state <= S_FIN;
        end
        S_CLS: begin
          cnt <= cnt + 12'd1;
          if (cnt[4:0] == 5'(c8_pkg::SCREEN_HEIGHT - 1)) begin
            state <= S_FIN;
          end
        end
        S_D0: begin
          // stop at the sprite height or the bottom edge
          if (cnt[4:0] == {1'b0, n} || drow[5]) begin
            state <= S_DFLAG;
          end else begin
            state <= S_D1;
          end
        end
        S_D1: begin
          coll  <= coll | (|(fb_rdata & smask));
          cnt   <= cnt + 12'd1;
          state <= S_D0;
        end
        S_DFLAG: state <= S_FIN;
        S_BCD: begin
          cnt <= cnt + 12'd1;
          if (cnt[1:0] == 2'd2) begin
            state <= S_FIN;
          end
        end
        S_ST0: state <= S_ST1;
        S_ST1: begin
          cnt   <= cnt + 12'd1;
          state <= (cnt[3:0] == x) ? S_FIN : S_ST0;
        end
        S_LD0: state <= S_LD1;
        S_LD1: begin
          cnt   <= cnt + 12'd1;
          state <= (cnt[3:0] == x) ? S_FIN : S_LD0;
        end
        S_FIN: begin
          done              <= 1'b1;
          program_counter   <= pc;
          opcode_executed   <= op;
          index_value       <= idx;
          flag_value        <= vf;
          key_wait          <= wait_q;
          row_pixels        <= pix;
          delay_timer_value <= dly;
          sound_timer_value <= snd;
          if (cmd == c8_pkg::CMD_EXEC) begin
            if (dly != 8'd0) begin
              dly               <= dly - 8'd1;
              delay_timer_value <= dly - 8'd1;
            end
            if (snd != 8'd0) begin
              snd               <= snd - 8'd1;
              sound_timer_value <= snd - 8'd1;
            end
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/c8_chk.sv]
// port-level checker for the chip-8 core, bound to the top level
module c8_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [15:0] opcode_executed,
  input logic        key_wait,
  input logic [63:0] row_pixels
);

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("transaction accepted but core not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while core busy");

  a_wait_op: assert property (@(posedge clk) disable iff (rst)
    done && key_wait |-> opcode_executed[15:12] == 4'hF &&
                         opcode_executed[7:0] == 8'h0A)
    else $error("key wait without a key wait opcode");

  a_row_noexec: assert property (@(posedge clk) disable iff (rst)
    done && row_pixels != 64'd0 |-> opcode_executed == 16'd0)
    else $error("row pixels on an execute transaction");

endmodule

bind eight_bit_vm_cpu_core_unit c8_chk u_c8_chk (
  .clk, .rst, .start, .busy, .done, .opcode_executed, .key_wait, .row_pixels);
